// ===== design/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, codes and character constants of the path-aware string compare.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CASE_FOLD    = 2'd0,
    REG_PATH_ORDER   = 2'd1,
    REG_LIMIT_ENABLE = 2'd2,
    REG_LIMIT_COUNT  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMP  = 2'd1,
    PH_SCAN = 2'd2
  } phase_t;

  localparam logic [1:0] ORDER_LESS    = 2'b11;
  localparam logic [1:0] ORDER_EQUAL   = 2'b00;
  localparam logic [1:0] ORDER_GREATER = 2'b01;

  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

  localparam logic signed [9:0] UPPER_TO_LOWER  = 10'sd32;
  localparam logic signed [9:0] SLASH_FROM_BACK = 10'sd47 - 10'sd92;

  typedef struct packed {
    logic                     case_fold;
    logic                     path_order;
    logic                     limit_enable;
    logic [CFG_DATA_BITS-1:0] limit_count;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   difference_sign;
    logic   side_a_done;
    logic   side_b_done;
    logic   side_a_has_folder;
    logic   side_b_has_folder;
  } state_t;

endpackage

`default_nettype wire

// ===== design/path_aware_string_compare.sv =====
// ----------------------------------------------------------------------------
// path_aware_string_compare
// Streaming ordering compare of two strings, one byte pair per word.
// ----------------------------------------------------------------------------
// Each input word carries one byte of string A and one of string B; a word
// with first_pair set starts a new comparison. A word is registered on
// acceptance, then folded, compared and folded into the compare state as it
// leaves the stage register, where any answer (-1, 0, +1) is loaded into the
// output register. One word is taken every cycle unless an answer waits
// untaken in the output register. The output register is the only thing
// that stalls the input: while an answer waits to be taken, the staged
// word holds.
// ----------------------------------------------------------------------------
`default_nettype none

module path_aware_string_compare #(
  parameter int COUNT_BITS = psc_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               first_pair,
  input  logic [7:0]                         byte_a,
  input  logic [7:0]                         byte_b,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [1:0]                  order,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [psc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [psc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import psc_pkg::*;

  cfg_t                  cfg;
  state_t                state, state_next;
  logic [COUNT_BITS-1:0] pairs_left, pairs_left_next;
  logic                  emit;
  logic [1:0]            order_next;

  logic                  stage_valid;
  logic                  stage_first;
  logic [7:0]            stage_a;
  logic [7:0]            stage_b;
  logic                  advance;

  psc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psc_step #(.COUNT_BITS(COUNT_BITS)) u_step (
    .cfg             (cfg),
    .state           (state),
    .pairs_left      (pairs_left),
    .first_pair      (stage_first),
    .byte_a          (stage_a),
    .byte_b          (stage_b),
    .state_next      (state_next),
    .pairs_left_next (pairs_left_next),
    .emit            (emit),
    .order_next      (order_next)
  );

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_first <= first_pair;
      stage_a     <= byte_a;
      stage_b     <= byte_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      pairs_left <= '0;
    end else if (advance) begin
      state      <= state_next;
      pairs_left <= pairs_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      order <= order_next;
    end
  end

  a_scan_not_finished: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_SCAN |-> !(state.side_a_done && state.side_b_done))
    else $error("scan phase held with both sides stopped");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_a) && $stable(stage_b))
    else $error("staged word lost while stalled");

  a_free_output_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_order_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> order != 2'b10)
    else $error("invalid order code");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !stage_valid && state.phase == PH_IDLE)
    else $error("control state not cleared by reset");

endmodule

`default_nettype wire

// ===== design/psc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// psc_cfg_regs
// Configuration register bank, written through a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [psc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [psc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output psc_pkg::cfg_t                      cfg
);
  import psc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_CASE_FOLD:    cfg.case_fold    <= cfg_data[0];
        REG_PATH_ORDER:   cfg.path_order   <= cfg_data[0];
        REG_LIMIT_ENABLE: cfg.limit_enable <= cfg_data[0];
        REG_LIMIT_COUNT:  cfg.limit_count  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/psc_step.sv =====
// ----------------------------------------------------------------------------
// psc_step
// Folds one byte pair, compares it and computes the next compare state.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_step #(
  parameter int COUNT_BITS = psc_pkg::COUNT_BITS_DEF
) (
  input  psc_pkg::cfg_t          cfg,
  input  psc_pkg::state_t        state,
  input  logic [COUNT_BITS-1:0]  pairs_left,
  input  logic                   first_pair,
  input  logic [7:0]             byte_a,
  input  logic [7:0]             byte_b,
  output psc_pkg::state_t        state_next,
  output logic [COUNT_BITS-1:0]  pairs_left_next,
  output logic                   emit,
  output logic [1:0]             order_next
);
  import psc_pkg::*;

  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

  logic [COUNT_BITS-1:0] pairs_load;
  logic signed [9:0]     d0, d1, d2, d3, d4;
  logic                  upper_a, upper_b, back_a, back_b;
  logic                  sep_a, sep_b;

  assign pairs_load = ({17'b0, cfg.limit_count} > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                             : COUNT_BITS'(cfg.limit_count);

  assign upper_a = (byte_a >= CHAR_UPPER_A) && (byte_a <= CHAR_UPPER_Z);
  assign upper_b = (byte_b >= CHAR_UPPER_A) && (byte_b <= CHAR_UPPER_Z);
  assign back_a  = (byte_a == CHAR_BACKSLASH);
  assign back_b  = (byte_b == CHAR_BACKSLASH);
  assign sep_a   = back_a || (byte_a == CHAR_SLASH);
  assign sep_b   = back_b || (byte_b == CHAR_SLASH);

  // fold step by step, stop once the difference is zero
  assign d0 = {{2{byte_a[7]}}, byte_a} - {{2{byte_b[7]}}, byte_b};
  assign d1 = (d0 != 0 && cfg.case_fold && upper_a)  ? d0 + UPPER_TO_LOWER  : d0;
  assign d2 = (d1 != 0 && cfg.path_order && back_a)  ? d1 + SLASH_FROM_BACK : d1;
  assign d3 = (d2 != 0 && cfg.case_fold && upper_b)  ? d2 - UPPER_TO_LOWER  : d2;
  assign d4 = (d3 != 0 && cfg.path_order && back_b)  ? d3 - SLASH_FROM_BACK : d3;

  always_comb begin
    state_next      = state;
    pairs_left_next = pairs_left;
    emit            = 1'b0;
    order_next      = ORDER_EQUAL;

    if (first_pair) begin
      state_next.phase             = PH_CMP;
      state_next.difference_sign   = 1'b0;
      state_next.side_a_done       = 1'b0;
      state_next.side_b_done       = 1'b0;
      state_next.side_a_has_folder = 1'b0;
      state_next.side_b_has_folder = 1'b0;
      pairs_left_next              = pairs_load;
    end

    if (first_pair && cfg.limit_enable && pairs_left_next == '0) begin
      emit             = 1'b1;
      state_next.phase = PH_IDLE;
    end else begin
      if (state_next.phase == PH_CMP) begin
        if (pairs_left_next != '0) begin
          pairs_left_next = pairs_left_next - COUNT_BITS'(1);
        end
        if (d4 != 0) begin
          if (!cfg.path_order) begin
            emit             = 1'b1;
            order_next       = d4[9] ? ORDER_LESS : ORDER_GREATER;
            state_next.phase = PH_IDLE;
          end else begin
            state_next.difference_sign = d4[9];
            state_next.phase           = PH_SCAN;
          end
        end else if (byte_a == CHAR_NUL) begin
          emit             = 1'b1;
          state_next.phase = PH_IDLE;
        end else if (cfg.limit_enable && pairs_left_next == '0) begin
          emit             = 1'b1;
          state_next.phase = PH_IDLE;
        end
      end

      // scan each side on to a separator or end of string
      if (state_next.phase == PH_SCAN && !emit) begin
        if (!state_next.side_a_done && (byte_a == CHAR_NUL || sep_a)) begin
          state_next.side_a_done       = 1'b1;
          state_next.side_a_has_folder = sep_a;
        end
        if (!state_next.side_b_done && (byte_b == CHAR_NUL || sep_b)) begin
          state_next.side_b_done       = 1'b1;
          state_next.side_b_has_folder = sep_b;
        end
        if (state_next.side_a_done && state_next.side_b_done) begin
          emit             = 1'b1;
          state_next.phase = PH_IDLE;
          priority if (state_next.side_a_has_folder && !state_next.side_b_has_folder) begin
            order_next = ORDER_LESS;
          end else if (!state_next.side_a_has_folder && state_next.side_b_has_folder) begin
            order_next = ORDER_GREATER;
          end else begin
            order_next = state_next.difference_sign ? ORDER_LESS : ORDER_GREATER;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
